// ===== rtl/hexatic_order_accumulator_macros.svh =====
// Assertion macros used by the checker of the hexatic order accumulator.
`ifndef HEXATIC_ORDER_ACCUMULATOR_MACROS_SVH
`define HEXATIC_ORDER_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and masked while arst_n is low.
`define HOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and masked while arst_n is low.
`define HOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hoa_pkg.sv =====
// Types, constants and helper functions of the hexatic order accumulator.
package hoa_pkg;

	localparam int MAX_NEIGHBORS = 64;
	localparam int CORDIC_STEPS  = 16;
	localparam int STEPS         = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam int COORD_W  = 24;
	localparam int BOX_W    = 23;
	localparam int K_W      = 4;
	localparam int PSI_W    = 24;
	localparam int CNT_W    = $clog2(MAX_NEIGHBORS + 1);
	localparam int FOLD_W   = 26;
	localparam int CW       = 45;
	localparam int ZW       = 34;
	localparam int ANG_W    = 32;
	localparam int STEP_W   = 5;
	localparam int Q16_W    = 18;
	localparam int DIV_STEPS = PSI_W;
	localparam int DSTEP_W  = $clog2(DIV_STEPS);
	localparam int KSTEP_W  = $clog2(K_W);
	localparam int PRESCALE_SH = 16;

	localparam logic signed [CW-1:0]    GAIN_Q30   = 652032874;
	localparam logic signed [CW-1:0]    RND_HALF   = 8192;
	localparam logic signed [CW-1:0]    Q16_ONE    = 65536;
	localparam logic signed [ZW-1:0]    TURN_HALF  = 34'sd2147483648;
	localparam logic signed [ZW-1:0]    TURN_QUART = 34'sd1073741824;

	localparam logic [1:0] CFG_BOX_X = 2'd0;
	localparam logic [1:0] CFG_BOX_Y = 2'd1;
	localparam logic [1:0] CFG_SYM   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_VEC,
		ST_MLOAD,
		ST_MUL,
		ST_RLOAD,
		ST_ROT,
		ST_ACC,
		ST_DSTART,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic vec;
		logic step;
	} cordic_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} serial_ctl_t;

	// Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
	function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [ANG_W-1:0] r;
		case (i)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10679838;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			5'd20:   r = 32'd652;
			5'd21:   r = 32'd326;
			5'd22:   r = 32'd163;
			5'd23:   r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] sq3(input logic [2:0] v);
		return 5'(v * v);
	endfunction

	// Single minimum-image step; a zero length leaves the offset alone.
	function automatic logic signed [FOLD_W-1:0] min_image(
		input logic signed [COORD_W-1:0] d,
		input logic [BOX_W-1:0] len
	);
		logic signed [FOLD_W:0] dw;
		logic signed [FOLD_W:0] lw;
		logic signed [FOLD_W:0] r;
		dw = (FOLD_W + 1)'(d);
		lw = $signed({{(FOLD_W + 1 - BOX_W){1'b0}}, len});
		r  = dw;
		if (len != '0) begin
			if ((dw <<< 1) > lw) begin
				r = dw - lw;
			end else if ((dw <<< 1) < -lw) begin
				r = dw + lw;
			end
		end
		return r[FOLD_W-1:0];
	endfunction

endpackage

// ===== rtl/hoa_ifs.sv =====
// Handshake channels of the hexatic order accumulator.
interface hoa_nbr_if import hoa_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] offset_x;
	logic signed [COORD_W-1:0] offset_y;
	logic                      has_neighbor;
	logic                      last_neighbor;

	modport source (output valid, offset_x, offset_y, has_neighbor, last_neighbor,
		input ready);
	modport sink (input valid, offset_x, offset_y, has_neighbor, last_neighbor,
		output ready);
endinterface

interface hoa_psi_if import hoa_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [PSI_W-1:0] psi_real;
	logic signed [PSI_W-1:0] psi_imag;
	logic [CNT_W-1:0]        neighbor_total;

	modport source (output valid, psi_real, psi_imag, neighbor_total, input ready);
	modport sink (input valid, psi_real, psi_imag, neighbor_total, output ready);
endinterface

interface hoa_cfg_if import hoa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       index;
	logic [BOX_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hexatic_order_accumulator.sv =====
// Hexatic order accumulator: per-particle bond orientational order psi_k from neighbor offsets.
// Each neighbor item carries a raw Q11.12 offset. The block folds it once into the periodic
// box (a zero box length leaves that axis unwrapped), drops offsets whose squared length is
// at most 16 raw units, and otherwise adds cos and sin of k times the bond angle to a complex
// sum; at most 64 neighbors count per particle. On the item marked last_neighbor the sum
// divided by k, rounded half away from zero, leaves as Q7.16 psi_real and psi_imag together
// with the count of contributing neighbors, and the sum clears. A symmetry_order of zero acts
// as one. Timing: items are taken one at a time. For a neighbor that contributes, one CORDIC
// datapath runs a vectoring pass for the angle and then a rotating pass for cos and sin, one
// iteration per cycle, with a bit-serial multiply by k between them. A last item adds the
// bit-serial division by k, plus any wait for a previous result still held in the output
// register. The configuration port is always ready; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module hexatic_order_accumulator import hoa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hoa_cfg_if.sink   cfg,
	hoa_nbr_if.sink   neighbor,
	hoa_psi_if.source result
);

	state_t state_q;
	state_t state_nxt;

	logic [BOX_W-1:0] box_x_q;
	logic [BOX_W-1:0] box_y_q;
	logic [K_W-1:0]   sym_q;
	logic [K_W-1:0]   fold_k;

	logic signed [FOLD_W-1:0] dx_q;
	logic signed [FOLD_W-1:0] dy_q;
	logic                     last_q;
	logic signed [PSI_W-1:0]  sum_re_q;
	logic signed [PSI_W-1:0]  sum_im_q;
	logic [CNT_W-1:0]         count_q;
	logic                     neg_q;

	logic                     out_valid_q;
	logic signed [PSI_W-1:0]  psi_re_q;
	logic signed [PSI_W-1:0]  psi_im_q;
	logic [CNT_W-1:0]         total_q;

	logic in_accept;
	logic act_in;
	logic near_zero;
	logic out_free;

	logic signed [FOLD_W-1:0] ax;
	logic signed [FOLD_W-1:0] ay;

	cordic_ctl_t          cord_ctl;
	logic signed [CW-1:0] cx_init;
	logic signed [CW-1:0] cy_init;
	logic signed [ZW-1:0] cz_init;
	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cy_q;
	logic signed [ZW-1:0] cz_q;
	logic                 cord_last;

	logic signed [CW-1:0] vx;
	logic signed [CW-1:0] vy;
	logic signed [ZW-1:0] rz;
	logic                 rneg;

	serial_ctl_t      mul_ctl;
	logic [ANG_W-1:0] prod_q;
	logic             mul_last;

	serial_ctl_t      div_ctl;
	logic [PSI_W-1:0] mag_re;
	logic [PSI_W-1:0] mag_im;
	logic [PSI_W-1:0] quo_re_q;
	logic [PSI_W-1:0] quo_im_q;
	logic             div_last;

	logic signed [CW-1:0]    cos_full;
	logic signed [CW-1:0]    sin_full;
	logic signed [CW-1:0]    cos_rnd;
	logic signed [CW-1:0]    sin_rnd;
	logic signed [Q16_W-1:0] cos_q16;
	logic signed [Q16_W-1:0] sin_q16;

	// Configuration registers; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= '0;
			box_y_q <= '0;
			sym_q   <= K_W'(6);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BOX_X: box_x_q <= cfg.data;
				CFG_BOX_Y: box_y_q <= cfg.data;
				CFG_SYM:   sym_q   <= cfg.data[K_W-1:0];
				default:   ;
			endcase
		end
	end

	assign fold_k = (sym_q == '0) ? K_W'(1) : sym_q;

	// Input side.
	assign neighbor.ready = (state_q == ST_IDLE);
	assign in_accept      = neighbor.valid && neighbor.ready;
	assign act_in         = neighbor.has_neighbor && (count_q < CNT_W'(MAX_NEIGHBORS));
	assign out_free       = !out_valid_q || result.ready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			dx_q   <= min_image(neighbor.offset_x, box_x_q);
			dy_q   <= min_image(neighbor.offset_y, box_y_q);
			last_q <= neighbor.last_neighbor;
		end
	end

	// An offset with squared length of 16 or less has both components within four.
	always_comb begin
		ax        = dx_q[FOLD_W-1] ? -dx_q : dx_q;
		ay        = dy_q[FOLD_W-1] ? -dy_q : dy_q;
		near_zero = (ax <= FOLD_W'(4)) && (ay <= FOLD_W'(4)) &&
			(({1'b0, sq3(ax[2:0])} + {1'b0, sq3(ay[2:0])}) <= 6'd16);
	end

	// Vectoring start: scale by 2^16 and move the vector into the right half plane.
	always_comb begin
		vx = CW'(dx_q) <<< PRESCALE_SH;
		vy = CW'(dy_q) <<< PRESCALE_SH;
		if (dx_q[FOLD_W-1]) begin
			vx = -vx;
			vy = -vy;
		end
	end

	// Rotation start: fold k*theta into a quarter turn around zero and note the flip.
	always_comb begin
		rz   = ZW'($signed(prod_q));
		rneg = 1'b0;
		if (rz > TURN_QUART) begin
			rz   = rz - TURN_HALF;
			rneg = 1'b1;
		end else if (rz < -TURN_QUART) begin
			rz   = rz + TURN_HALF;
			rneg = 1'b1;
		end
	end

	always_comb begin
		cx_init = GAIN_Q30;
		cy_init = '0;
		cz_init = rz;
		if (state_q == ST_PREP) begin
			cx_init = vx;
			cy_init = vy;
			cz_init = dx_q[FOLD_W-1] ? TURN_HALF : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RLOAD) begin
			neg_q <= rneg;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (act_in) begin
						state_nxt = ST_PREP;
					end else if (neighbor.last_neighbor) begin
						state_nxt = ST_DSTART;
					end
				end
			end
			ST_PREP: begin
				if (near_zero) begin
					state_nxt = last_q ? ST_DSTART : ST_IDLE;
				end else begin
					state_nxt = ST_VEC;
				end
			end
			ST_VEC:    if (cord_last) state_nxt = ST_MLOAD;
			ST_MLOAD:  state_nxt = ST_MUL;
			ST_MUL:    if (mul_last) state_nxt = ST_RLOAD;
			ST_RLOAD:  state_nxt = ST_ROT;
			ST_ROT:    if (cord_last) state_nxt = ST_ACC;
			ST_ACC:    state_nxt = last_q ? ST_DSTART : ST_IDLE;
			ST_DSTART: state_nxt = ST_DIV;
			ST_DIV:    if (div_last) state_nxt = ST_DONE;
			ST_DONE:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		cord_ctl.load = ((state_q == ST_PREP) && !near_zero) || (state_q == ST_RLOAD);
		cord_ctl.vec  = (state_q == ST_PREP);
		cord_ctl.step = (state_q == ST_VEC) || (state_q == ST_ROT);
		mul_ctl.load  = (state_q == ST_MLOAD);
		mul_ctl.step  = (state_q == ST_MUL);
		div_ctl.load  = (state_q == ST_DSTART);
		div_ctl.step  = (state_q == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	hoa_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cord_ctl),
		.x_init (cx_init),
		.y_init (cy_init),
		.z_init (cz_init),
		.x_q    (cx_q),
		.y_q    (cy_q),
		.z_q    (cz_q),
		.last   (cord_last)
	);

	hoa_kmul u_kmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.angle  (cz_q[ANG_W-1:0]),
		.fold   (fold_k),
		.prod_q (prod_q),
		.last   (mul_last)
	);

	// Round the Q2.30 rotation result to Q16 and clamp to plus or minus one.
	always_comb begin
		cos_full = neg_q ? -cx_q : cx_q;
		sin_full = neg_q ? -cy_q : cy_q;
		cos_rnd  = (cos_full + RND_HALF) >>> 14;
		sin_rnd  = (sin_full + RND_HALF) >>> 14;
		if (cos_rnd > Q16_ONE) begin
			cos_q16 = Q16_W'(Q16_ONE);
		end else if (cos_rnd < -Q16_ONE) begin
			cos_q16 = Q16_W'(-Q16_ONE);
		end else begin
			cos_q16 = cos_rnd[Q16_W-1:0];
		end
		if (sin_rnd > Q16_ONE) begin
			sin_q16 = Q16_W'(Q16_ONE);
		end else if (sin_rnd < -Q16_ONE) begin
			sin_q16 = Q16_W'(-Q16_ONE);
		end else begin
			sin_q16 = sin_rnd[Q16_W-1:0];
		end
	end

	// Running sums; the result commit clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
			count_q  <= '0;
		end else if (state_q == ST_ACC) begin
			sum_re_q <= sum_re_q + PSI_W'(cos_q16);
			sum_im_q <= sum_im_q + PSI_W'(sin_q16);
			count_q  <= count_q + 1'b1;
		end else if ((state_q == ST_DONE) && out_free) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
			count_q  <= '0;
		end
	end

	// Division works on magnitudes with half the divisor added, for rounding away from zero.
	always_comb begin
		mag_re = PSI_W'(sum_re_q[PSI_W-1] ? -sum_re_q : sum_re_q) + PSI_W'(fold_k >> 1);
		mag_im = PSI_W'(sum_im_q[PSI_W-1] ? -sum_im_q : sum_im_q) + PSI_W'(fold_k >> 1);
	end

	hoa_serdiv u_serdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.mag_re   (mag_re),
		.mag_im   (mag_im),
		.divisor  (fold_k),
		.quo_re_q (quo_re_q),
		.quo_im_q (quo_im_q),
		.last     (div_last)
	);

	// Output register; it frees the sequencer as soon as a result is parked here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			psi_re_q <= sum_re_q[PSI_W-1] ? -$signed(quo_re_q) : $signed(quo_re_q);
			psi_im_q <= sum_im_q[PSI_W-1] ? -$signed(quo_im_q) : $signed(quo_im_q);
			total_q  <= count_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.psi_real       = psi_re_q;
	assign result.psi_imag       = psi_im_q;
	assign result.neighbor_total = total_q;

endmodule

// ===== rtl/hoa_cordic.sv =====
// Iterative CORDIC shared by the vectoring and the rotating pass.
module hoa_cordic import hoa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cordic_ctl_t          ctl,
	input  logic signed [CW-1:0] x_init,
	input  logic signed [CW-1:0] y_init,
	input  logic signed [ZW-1:0] z_init,
	output logic signed [CW-1:0] x_q,
	output logic signed [CW-1:0] y_q,
	output logic signed [ZW-1:0] z_q,
	output logic                 last
);

	logic [STEP_W-1:0]    step_q;
	logic                 vec_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] at;
	logic                 up;

	assign last = (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = $signed({{(ZW - ANG_W){1'b0}}, atan_turn(step_q)});
		// Vectoring drives y toward zero, rotation drives z toward zero.
		up = vec_q ? (y_q <= 0) : (z_q >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			vec_q  <= 1'b0;
		end else if (ctl.load) begin
			step_q <= '0;
			vec_q  <= ctl.vec;
		end else if (ctl.step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (ctl.step) begin
			if (up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

endmodule

// ===== rtl/hoa_kmul.sv =====
// Shift-and-add multiplier of the angle by the fold, one bit of the fold per cycle.
module hoa_kmul import hoa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  serial_ctl_t      ctl,
	input  logic [ANG_W-1:0] angle,
	input  logic [K_W-1:0]   fold,
	output logic [ANG_W-1:0] prod_q,
	output logic             last
);

	logic [KSTEP_W-1:0] cnt_q;
	logic [ANG_W-1:0]   mcand_q;
	logic [K_W-1:0]     mplier_q;

	assign last = (cnt_q == KSTEP_W'(K_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Product wraps modulo one turn, as the angle does.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q  <= angle;
			mplier_q <= fold;
			prod_q   <= '0;
		end else if (ctl.step) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

// ===== rtl/hoa_serdiv.sv =====
// Restoring divider of both sum magnitudes by the fold, one quotient bit per cycle.
module hoa_serdiv import hoa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  serial_ctl_t      ctl,
	input  logic [PSI_W-1:0] mag_re,
	input  logic [PSI_W-1:0] mag_im,
	input  logic [K_W-1:0]   divisor,
	output logic [PSI_W-1:0] quo_re_q,
	output logic [PSI_W-1:0] quo_im_q,
	output logic             last
);

	logic [DSTEP_W-1:0] cnt_q;
	logic [K_W-1:0]     dvs_q;
	logic [K_W-1:0]     rem_re_q;
	logic [K_W-1:0]     rem_im_q;
	logic [K_W:0]       try_re;
	logic [K_W:0]       try_im;
	logic               fit_re;
	logic               fit_im;

	assign last = (cnt_q == DSTEP_W'(DIV_STEPS - 1));

	always_comb begin
		try_re = {rem_re_q, quo_re_q[PSI_W-1]};
		try_im = {rem_im_q, quo_im_q[PSI_W-1]};
		fit_re = (try_re >= {1'b0, dvs_q});
		fit_im = (try_im >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_re_q <= mag_re;
			quo_im_q <= mag_im;
			rem_re_q <= '0;
			rem_im_q <= '0;
			dvs_q    <= divisor;
		end else if (ctl.step) begin
			quo_re_q <= {quo_re_q[PSI_W-2:0], fit_re};
			quo_im_q <= {quo_im_q[PSI_W-2:0], fit_im};
			rem_re_q <= fit_re ? K_W'(try_re - {1'b0, dvs_q}) : try_re[K_W-1:0];
			rem_im_q <= fit_im ? K_W'(try_im - {1'b0, dvs_q}) : try_im[K_W-1:0];
		end
	end

endmodule

// ===== rtl/hoa_checker.sv =====
// Port-level checker of the hexatic order accumulator and its bind.
`include "hexatic_order_accumulator_macros.svh"

module hoa_checker import hoa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             n_valid,
	input logic             n_ready,
	input logic             n_last,
	input logic             r_valid,
	input logic             r_ready,
	input logic [CNT_W-1:0] r_total
);

	`HOA_ASSERT_NEXT(a_result_held, r_valid && !r_ready, r_valid, "result dropped while stalled")
	`HOA_ASSERT_NOW(a_total_range, r_valid, r_total <= CNT_W'(MAX_NEIGHBORS), "count too large")
	`HOA_ASSERT_NEXT(a_busy_after_last, n_valid && n_ready && n_last, !n_ready, "ready during close")

endmodule

bind hexatic_order_accumulator hoa_checker u_hoa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.n_valid (neighbor.valid),
	.n_ready (neighbor.ready),
	.n_last  (neighbor.last_neighbor),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_total (result.neighbor_total)
);

// ===== verif/hexatic_order_accumulator_test.sv =====
// Self-checking testbench of the hexatic order accumulator: directed table, then random particles.
`timescale 1ns / 1ps

module hexatic_order_accumulator_test;
	import hoa_pkg::*;

	// One neighbor item as the sender offers it.
	typedef struct {
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		logic                      has;
		logic                      last;
	} nbr_item_t;

	// One psi result of a closed particle.
	typedef struct {
		logic signed [PSI_W-1:0] re;
		logic signed [PSI_W-1:0] im;
		logic [CNT_W-1:0]        cnt;
	} psi_item_t;

	// A row of the directed table. When typed is set, the row carries an expected
	// result that can be read straight off the behavior; otherwise the predictor decides.
	typedef struct {
		nbr_item_t item;
		bit        typed;
		psi_item_t want;
	} row_t;

	localparam int    LIMIT_CYCLES = 1500000;
	localparam int    SETTLE       = 120;
	localparam longint TURN        = 64'sd4294967296;
	localparam longint ANGLE_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic clk;
	logic arst_n;

	hoa_cfg_if cfg_ch();
	hoa_nbr_if nbr_ch();
	hoa_psi_if psi_ch();

	hexatic_order_accumulator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.neighbor(nbr_ch),
		.result(psi_ch)
	);

	// Predictor copy of the configuration and of the per-particle accumulator.
	logic [BOX_W-1:0] box_x;
	logic [BOX_W-1:0] box_y;
	logic [K_W-1:0]   fold_k;
	longint           sum_re;
	longint           sum_im;
	int               nbr_count;

	psi_item_t pending_psi[$];
	int        mismatches;
	int        cycles;

	// Knobs of the sender and the receiver process: percentages of items or cycles that start a gap, and a hold-off.
	int send_gap_pct;
	int recv_gap_pct;
	int recv_hold;

	always #2 clk = ~clk;

	// Gap length: mostly short, now and then a long pause.
	function automatic int pick_gap();
		if ($urandom_range(99) < 85) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(60, 10);
	endfunction

	// Bond angle of (dx, dy) as a 32-bit fraction of a turn, vectoring CORDIC.
	function automatic logic [31:0] bond_angle(input longint dx, input longint dy);
		longint      x;
		longint      y;
		longint      xs;
		longint      ys;
		logic [31:0] z;
		x = dx * 65536;
		y = dy * 65536;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ANGLE_STEP[i][31:0];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ANGLE_STEP[i][31:0];
			end
		end
		return z;
	endfunction

	// Q2.30 to Q16 with rounding and a clamp to plus or minus one.
	function automatic longint round_q16(input longint v);
		longint r;
		r = (v + 8192) >>> 14;
		if (r > 65536) r = 65536;
		if (r < -65536) r = -65536;
		return r;
	endfunction

	// Cos and sin of a turn fraction by a rotating CORDIC, after folding into a half turn.
	function automatic void unit_vector(input logic [31:0] a, output longint c, output longint s);
		longint z;
		longint x;
		longint y;
		longint xs;
		longint ys;
		bit     flip;
		z = a[31] ? longint'(a) - TURN : longint'(a);
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ANGLE_STEP[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ANGLE_STEP[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_q16(x);
		s = round_q16(y);
	endfunction

	// One minimum-image step along an axis; zero length means the axis does not wrap.
	function automatic longint wrap_axis(input longint d, input longint len);
		if (len == 0) return d;
		if (2 * d > len) return d - len;
		if (2 * d < -len) return d + len;
		return d;
	endfunction

	// Divide by the fold, rounding half away from zero.
	function automatic longint fold_divide(input longint v, input longint k);
		longint m;
		longint q;
		m = (v < 0) ? -v : v;
		q = (m + k / 2) / k;
		return (v < 0) ? -q : q;
	endfunction

	// Applies one accepted item to the predicted accumulator; returns 1 when it closes
	// a particle, with the expected result in r.
	function automatic bit accumulate_psi(input nbr_item_t it, output psi_item_t r);
		longint      k;
		longint      dx;
		longint      dy;
		longint      c;
		longint      s;
		logic [31:0] ang;
		k = (fold_k == 0) ? 1 : fold_k;
		r = '{re: '0, im: '0, cnt: '0};
		if (it.has && nbr_count < MAX_NEIGHBORS) begin
			dx = wrap_axis(longint'(it.ox), longint'(box_x));
			dy = wrap_axis(longint'(it.oy), longint'(box_y));
			// Offsets of squared length 16 raw units or less are treated as coincident.
			if (dx * dx + dy * dy >= 17) begin
				ang = bond_angle(dx, dy);
				ang = 32'(ang * 32'(k));
				unit_vector(ang, c, s);
				sum_re = sum_re + c;
				sum_im = sum_im + s;
				nbr_count++;
			end
		end
		if (!it.last) return 0;
		r.re  = PSI_W'(fold_divide(sum_re, k));
		r.im  = PSI_W'(fold_divide(sum_im, k));
		r.cnt = CNT_W'(nbr_count);
		sum_re = 0;
		sum_im = 0;
		nbr_count = 0;
		return 1;
	endfunction

	// Offers one item with a random gap in front and records its expectation once taken.
	task automatic send_neighbor(input nbr_item_t it, input bit typed, input psi_item_t want);
		psi_item_t r;
		int        gap;
		gap = ($urandom_range(99) < send_gap_pct) ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			nbr_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		nbr_ch.offset_x      = it.ox;
		nbr_ch.offset_y      = it.oy;
		nbr_ch.has_neighbor  = it.has;
		nbr_ch.last_neighbor = it.last;
		nbr_ch.valid         = 1'b1;
		do @(posedge clk); while (!nbr_ch.ready);
		if (accumulate_psi(it, r)) begin
			pending_psi.push_back(typed ? want : r);
		end
	endtask

	// Lowers the neighbor valid and waits for every outstanding result, then for the
	// block to finish any item that produced none.
	task automatic drain_results();
		@(negedge clk);
		nbr_ch.valid = 1'b0;
		while (pending_psi.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [BOX_W-1:0] value);
		@(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_BOX_X: box_x = value;
			CFG_BOX_Y: box_y = value;
			CFG_SYM:   fold_k = value[K_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Random offset: full range, tiny offsets around the coincidence limit, offsets near
	// the half-box wrap threshold, or ordinary bond lengths of a few units.
	function automatic logic signed [COORD_W-1:0] pick_offset(input logic [BOX_W-1:0] len);
		int sel;
		sel = $urandom_range(99);
		if (sel < 25) return COORD_W'($urandom());
		if (sel < 35) return COORD_W'($signed(24'($urandom_range(10))) - 5);
		if (sel < 50 && len != 0) begin
			return COORD_W'(($urandom_range(1) ? 1 : -1) * ($signed({1'b0, len}) / 2)
				+ $signed(24'($urandom_range(4))) - 2);
		end
		return COORD_W'($signed(24'($urandom_range(16384))) - 8192);
	endfunction

	// A random particle: mostly a handful of neighbors, sometimes more than the
	// neighbor cap, sometimes empty, with stray empty items mixed in.
	task automatic send_particle(output int sent);
		nbr_item_t it;
		int        n;
		int        sel;
		psi_item_t none;
		none = '{re: '0, im: '0, cnt: '0};
		sel = $urandom_range(99);
		n = (sel < 6) ? 0 : (sel < 10) ? $urandom_range(70, 60) : $urandom_range(12, 1);
		sent = 0;
		for (int i = 0; i < n; i++) begin
			it.ox   = pick_offset(box_x);
			it.oy   = pick_offset(box_y);
			it.has  = ($urandom_range(19) != 0);
			it.last = 1'b0;
			send_neighbor(it, 0, none);
			sent++;
		end
		it.ox   = COORD_W'($urandom());
		it.oy   = COORD_W'($urandom());
		it.has  = (n == 0) ? 1'b0 : 1'($urandom_range(1));
		it.last = 1'b1;
		send_neighbor(it, 0, none);
		sent++;
	endtask

	// Receiver: ready drops for random gaps, or for a requested long hold-off.
	initial begin
		int gap_left;
		gap_left = 0;
		psi_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				psi_ch.ready = 1'b0;
				recv_hold--;
			end else if (gap_left > 0) begin
				psi_ch.ready = 1'b0;
				gap_left--;
			end else begin
				psi_ch.ready = 1'b1;
				if ($urandom_range(99) < recv_gap_pct) gap_left = pick_gap();
			end
		end
	end

	// Scoreboard: each result taken is compared with the oldest expectation.
	always @(posedge clk) begin
		psi_item_t e;
		if (arst_n && psi_ch.valid && psi_ch.ready) begin
			if (pending_psi.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result re=%0d im=%0d n=%0d", psi_ch.psi_real,
						psi_ch.psi_imag, psi_ch.neighbor_total);
				end
			end else begin
				e = pending_psi.pop_front();
				if (psi_ch.psi_real !== e.re || psi_ch.psi_imag !== e.im ||
					psi_ch.neighbor_total !== e.cnt) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("psi mismatch: expected re=%0d im=%0d n=%0d, got re=%0d im=%0d n=%0d",
							e.re, e.im, e.cnt, psi_ch.psi_real, psi_ch.psi_imag,
							psi_ch.neighbor_total);
					end
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		row_t              rows[$];
		psi_item_t         zero;
		psi_item_t         none;
		int                sent;
		int                total;
		logic [BOX_W-1:0]  bx;
		logic [BOX_W-1:0]  by;
		logic [K_W-1:0]    kk;

		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		mismatches = 0;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		recv_hold = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BOX_X;
		cfg_ch.data = '0;
		nbr_ch.valid = 1'b0;
		nbr_ch.offset_x = '0;
		nbr_ch.offset_y = '0;
		nbr_ch.has_neighbor = 1'b0;
		nbr_ch.last_neighbor = 1'b0;
		box_x = '0;
		box_y = '0;
		fold_k = 4'd6;
		sum_re = 0;
		sum_im = 0;
		nbr_count = 0;
		zero = '{re: '0, im: '0, cnt: '0};
		none = zero;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset configuration (no wrap, sixfold).
		// Empty particle: a lone closing item gives zeros and no neighbors.
		rows.push_back('{'{24'sd0, 24'sd0, 1'b0, 1'b1}, 1, zero});
		// Coincident offset of squared length exactly 16 is dropped.
		rows.push_back('{'{24'sd4, 24'sd0, 1'b1, 1'b1}, 1, zero});
		rows.push_back('{'{24'sd0, 24'sd0, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sd0, -24'sd4, 1'b1, 1'b1}, 1, zero});
		// Field extremes in every quadrant, just past the coincidence limit, and an
		// empty item in the middle of a particle that must change nothing.
		rows.push_back('{'{24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sh800000, 24'sh800000, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sh800000, 24'sh7FFFFF, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sd4, 24'sd1, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sh7FFFFF, 24'sh800000, 1'b0, 1'b0}, 0, none});
		rows.push_back('{'{24'sd4096, 24'sd0, 1'b1, 1'b1}, 0, none});
		// Axis directions, including the negative x axis and just below the cut; the item just above it is empty.
		rows.push_back('{'{-24'sd4096, 24'sd0, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sd0, 24'sd4096, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{24'sd0, -24'sd4096, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{-24'sd4096, -24'sd1, 1'b1, 1'b0}, 0, none});
		rows.push_back('{'{-24'sd4096, 24'sd1, 1'b0, 1'b1}, 0, none});
		foreach (rows[i]) send_neighbor(rows[i].item, rows[i].typed, rows[i].want);
		drain_results();

		// Random phases, each under its own configuration. The first phase holds the
		// receiver off for a long stretch while the sender streams, so the block backs up.
		total = 0;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin bx = '0; by = '0; kk = 4'd6; end
				1: begin bx = 23'h7FFFFF; by = 23'h7FFFFF; kk = 4'd1; end
				2: begin bx = 23'd40960; by = 23'd1; kk = 4'd12; end
				3: begin bx = 23'd1; by = 23'd0; kk = 4'd0; end
				4: begin bx = BOX_W'($urandom()); by = BOX_W'($urandom()); kk = 4'd15; end
				5: begin bx = 23'($urandom_range(65536, 2)); by = bx; kk = 4'd13; end
				default: begin
					bx = BOX_W'($urandom());
					by = BOX_W'($urandom());
					kk = K_W'($urandom());
				end
			endcase
			write_reg(CFG_BOX_X, bx);
			write_reg(CFG_BOX_Y, by);
			write_reg(CFG_SYM, {{(BOX_W - K_W){1'b0}}, kk});
			// Every third phase runs without any idling; the others insert random gaps.
			send_gap_pct = (ph % 3 == 2) ? 0 : 25;
			recv_gap_pct = (ph % 3 == 2) ? 0 : 30;
			if (ph == 0) begin
				send_gap_pct = 0;
				recv_hold = 3000;
			end
			sent = 0;
			while (sent < 160) begin
				send_particle(total);
				sent += total;
				// Midway through one phase the sender waits for every result.
				if (ph == 3 && sent >= 80 && sent < 80 + total) begin
					@(negedge clk);
					nbr_ch.valid = 1'b0;
					while (pending_psi.size() != 0) @(posedge clk);
				end
			end
			drain_results();
		end

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
